// ----- src/pfc_pkg.sv -----
// Package for the pixel format converter: format codes, register indexes,
// and the channel widening and narrowing functions.
// Used by pixel_format_converter and its checker; no dependencies.
package pfc_pkg;

   // pixel format codes, shared by the source and destination registers
   typedef enum logic [2:0] {
      FMT_RGB888   = 3'd0,
      FMT_RGB565   = 3'd1,
      FMT_XRGB1555 = 3'd2,
      FMT_ARGB1555 = 3'd3,
      FMT_ARGB4444 = 3'd4,
      FMT_ARGB8888 = 3'd5,
      FMT_XRGB8888 = 3'd6,
      FMT_RGBA     = 3'd7
   } fmt_type;

   // register indexes on the csr port
   localparam int CsrIndexWidth = 2;
   localparam logic [CsrIndexWidth-1:0] REG_SOURCE_FORMAT = 2'd0;
   localparam logic [CsrIndexWidth-1:0] REG_DEST_FORMAT   = 2'd1;
   localparam logic [CsrIndexWidth-1:0] REG_COLOR_KEY     = 2'd2;

   localparam int CsrDataWidth = 32;
   localparam fmt_type FormatReset = FMT_ARGB8888;

   // byte counts reported with each word
   localparam logic [2:0] BYTES_16 = 3'd2;
   localparam logic [2:0] BYTES_24 = 3'd3;
   localparam logic [2:0] BYTES_32 = 3'd4;

   // reciprocal constants: floor(x/31) for x <= 217 is (x*265) >> 13,
   // floor(x/255) for x < 65536 is (x*32897) >> 23, folded with the 31 or 63
   localparam logic [8:0]  Recip31     = 9'd265;
   localparam logic [19:0] Narrow5Mul  = 20'd1019807;  // 31 * 32897
   localparam logic [20:0] Narrow6Mul  = 21'd2072511;  // 63 * 32897

   typedef struct packed {
      logic [7:0] r;
      logic [7:0] g;
      logic [7:0] b;
      logic [7:0] a;
   } rgba_type;

   // v*255/31 = 8v + floor(7v/31)
   function automatic logic [7:0] widen5(input logic [4:0] v);
      logic [7:0]  v7;
      logic [15:0] prod;
      v7   = {v, 3'b000} - {3'b000, v};
      prod = 16'(v7) * 16'(Recip31);
      return {v, 3'b000} + {5'b00000, prod[15:13]};
   endfunction

   // v*255/63 = 4v + floor(v/21)
   function automatic logic [7:0] widen6(input logic [5:0] v);
      logic [1:0] q;
      q = 2'(v >= 6'd21) + 2'(v >= 6'd42) + 2'(v >= 6'd63);
      return {v, 2'b00} + {6'b000000, q};
   endfunction

   // floor(c*31/255)
   function automatic logic [4:0] narrow5(input logic [7:0] c);
      logic [27:0] prod;
      prod = 28'(c) * 28'(Narrow5Mul);
      return prod[27:23];
   endfunction

   // floor(c*63/255)
   function automatic logic [5:0] narrow6(input logic [7:0] c);
      logic [28:0] prod;
      prod = 29'(c) * 29'(Narrow6Mul);
      return prod[28:23];
   endfunction

endpackage

// ----- src/pixel_format_converter.sv -----
// Path from req accept to rsp_valid: input register, then result register.
// Throughput: one word per cycle; the input register can still take a word while
// the result register waits on rsp_stall, so req_stall only rises when both hold one.
// Reset (synchronous, active high): both stages empty, source_format and
// dest_format return to argb8888, color_key to zero (keying off).
// Top level of the pixel format converter; uses pfc_pkg.
module pixel_format_converter (
   input  logic        clock,
   input  logic        reset,
   // input channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_source_pixel,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_dest_pixel,
   output logic [2:0]  rsp_dest_bytes,
   // configuration
   input  logic                                csr_wr_en,
   input  logic [pfc_pkg::CsrIndexWidth-1:0]   csr_index,
   input  logic [pfc_pkg::CsrDataWidth-1:0]    csr_wr_data
);

   pfc_pkg::fmt_type  src_fmt_ff, dst_fmt_ff;
   logic [31:0]       color_key_ff;

   logic              in_valid_ff;
   logic [31:0]       in_pixel_ff;
   logic              out_valid_ff;
   logic [31:0]       out_pixel_ff, out_pixel_in;
   logic [2:0]        out_bytes_ff, out_bytes_in;

   logic              out_load;
   logic              in_load;
   pfc_pkg::rgba_type dec;
   logic [15:0]       half;
   logic              key_hit;
   logic [7:0]        alpha;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         src_fmt_ff   <= pfc_pkg::FormatReset;
         dst_fmt_ff   <= pfc_pkg::FormatReset;
         color_key_ff <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            pfc_pkg::REG_SOURCE_FORMAT: src_fmt_ff <= pfc_pkg::fmt_type'(csr_wr_data[2:0]);
            pfc_pkg::REG_DEST_FORMAT:   dst_fmt_ff <= pfc_pkg::fmt_type'(csr_wr_data[2:0]);
            pfc_pkg::REG_COLOR_KEY:     color_key_ff <= csr_wr_data;
            default: ;
         endcase
      end
   end

   // pipeline flow: result register loads when empty or drained
   assign out_load  = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign in_load   = req_valid && !req_stall;
   assign req_stall = in_valid_ff && out_valid_ff && rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (in_load)
            in_valid_ff <= 1'b1;
         else if (out_load)
            in_valid_ff <= 1'b0;
         if (out_load)
            out_valid_ff <= 1'b1;
         else if (!rsp_stall)
            out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (in_load)
         in_pixel_ff <= req_source_pixel;
      if (out_load) begin
         out_pixel_ff <= out_pixel_in;
         out_bytes_ff <= out_bytes_in;
      end
   end

   // decode to 8-bit channels
   assign half = in_pixel_ff[15:0];
   always_comb begin
      dec.r = in_pixel_ff[23:16];
      dec.g = in_pixel_ff[15:8];
      dec.b = in_pixel_ff[7:0];
      dec.a = in_pixel_ff[31:24];
      case (src_fmt_ff)
         pfc_pkg::FMT_RGB888, pfc_pkg::FMT_XRGB8888: begin
            dec.a = 8'hff;
         end
         pfc_pkg::FMT_RGB565: begin
            dec.r = pfc_pkg::widen5(half[15:11]);
            dec.g = pfc_pkg::widen6(half[10:5]);
            dec.b = pfc_pkg::widen5(half[4:0]);
            dec.a = 8'hff;
         end
         pfc_pkg::FMT_XRGB1555, pfc_pkg::FMT_ARGB1555: begin
            dec.r = pfc_pkg::widen5(half[14:10]);
            dec.g = pfc_pkg::widen5(half[9:5]);
            dec.b = pfc_pkg::widen5(half[4:0]);
            dec.a = (src_fmt_ff == pfc_pkg::FMT_ARGB1555 && !half[15]) ? 8'h00 : 8'hff;
         end
         pfc_pkg::FMT_ARGB4444: begin
            dec.r = {half[11:8], half[11:8]};
            dec.g = {half[7:4], half[7:4]};
            dec.b = {half[3:0], half[3:0]};
            dec.a = {half[15:12], half[15:12]};
         end
         pfc_pkg::FMT_RGBA: begin
            dec.r = in_pixel_ff[7:0];
            dec.b = in_pixel_ff[23:16];
         end
         default: ;
      endcase
   end

   // color key: a nonzero key whose RGB matches clears alpha
   assign key_hit = (color_key_ff != 32'd0) && (color_key_ff[23:0] == {dec.r, dec.g, dec.b});
   assign alpha   = key_hit ? 8'h00 : dec.a;

   // encode to the destination format
   always_comb begin
      out_pixel_in = {alpha, dec.r, dec.g, dec.b};
      out_bytes_in = pfc_pkg::BYTES_32;
      case (dst_fmt_ff)
         pfc_pkg::FMT_RGB888: begin
            out_pixel_in = {8'h00, dec.r, dec.g, dec.b};
            out_bytes_in = pfc_pkg::BYTES_24;
         end
         pfc_pkg::FMT_RGB565: begin
            out_pixel_in = {16'h0000, pfc_pkg::narrow5(dec.r), pfc_pkg::narrow6(dec.g),
                            pfc_pkg::narrow5(dec.b)};
            out_bytes_in = pfc_pkg::BYTES_16;
         end
         pfc_pkg::FMT_XRGB1555, pfc_pkg::FMT_ARGB1555: begin
            out_pixel_in = {16'h0000,
                            (dst_fmt_ff == pfc_pkg::FMT_XRGB1555) || alpha[7],
                            pfc_pkg::narrow5(dec.r), pfc_pkg::narrow5(dec.g),
                            pfc_pkg::narrow5(dec.b)};
            out_bytes_in = pfc_pkg::BYTES_16;
         end
         pfc_pkg::FMT_ARGB4444: begin
            out_pixel_in = {16'h0000, alpha[7:4], dec.r[7:4], dec.g[7:4], dec.b[7:4]};
            out_bytes_in = pfc_pkg::BYTES_16;
         end
         pfc_pkg::FMT_XRGB8888: begin
            out_pixel_in = {8'hff, dec.r, dec.g, dec.b};
         end
         default: ;
      endcase
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_dest_pixel = out_pixel_ff;
   assign rsp_dest_bytes = out_bytes_ff;

endmodule

// ----- src/pfc_checker.sv -----
// Port-level checks for the pixel format converter, bound to the top level.
// Uses pfc_pkg for byte-count constants.
module pfc_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_dest_pixel,
   input logic [2:0]  rsp_dest_bytes
);

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_dest_pixel)
                                  && $stable(rsp_dest_bytes))
      else $error("stalled result changed");

   // byte count is one of the three sizes
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_dest_bytes == pfc_pkg::BYTES_16
                 || rsp_dest_bytes == pfc_pkg::BYTES_24
                 || rsp_dest_bytes == pfc_pkg::BYTES_32)
      else $error("bad byte count");

   // 16-bit words leave the upper half clear
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_dest_bytes == pfc_pkg::BYTES_16 |-> rsp_dest_pixel[31:16] == 16'h0000)
      else $error("16-bit word has upper bits set");

   // 24-bit words leave the top byte clear
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_dest_bytes == pfc_pkg::BYTES_24 |-> rsp_dest_pixel[31:24] == 8'h00)
      else $error("24-bit word has top byte set");

   // reset empties the result register
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind pixel_format_converter pfc_checker u_pfc_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_dest_pixel (rsp_dest_pixel),
   .rsp_dest_bytes (rsp_dest_bytes)
);

// ----- dv/tb_pixel_format_converter.sv -----
// Testbench for pixel_format_converter: directed table of format and keying corner
// cases, then random pixels over many register settings, checked by an in-bench converter.
// Depends on pfc_pkg (format codes, register indexes, byte counts) and the RTL top.
module tb_pixel_format_converter;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CycleLimit = 300000;
   localparam int HoldCycles = 200;
   localparam int NumDirected = 25;
   localparam int WordsPerSetting = 50;
   // index 3 is not a register; writes to it must be ignored
   localparam logic [pfc_pkg::CsrIndexWidth-1:0] REG_SPARE = 2'd3;

   typedef struct packed {
      logic [7:0] r;
      logic [7:0] g;
      logic [7:0] b;
      logic [7:0] a;
   } channels_type;

   typedef struct packed {
      logic [31:0] pixel;
      logic [2:0]  nbytes;
   } dest_word_type;

   typedef struct packed {
      pfc_pkg::fmt_type src;
      pfc_pkg::fmt_type dst;
      logic [31:0]      key;
      logic [31:0]      pixel;
      logic             typed;
      logic [31:0]      want_pixel;
      logic [2:0]       want_bytes;
   } directed_row_type;

   // format corners; the expected word is typed in where it is obvious
   localparam directed_row_type DirectedRows [NumDirected] = '{
      '{pfc_pkg::FMT_ARGB8888, pfc_pkg::FMT_ARGB8888, 32'h0, 32'h1234_5678,
        1'b1, 32'h1234_5678, pfc_pkg::BYTES_32},
      '{pfc_pkg::FMT_ARGB8888, pfc_pkg::FMT_ARGB8888, 32'h0, 32'hFFFF_FFFF,
        1'b1, 32'hFFFF_FFFF, pfc_pkg::BYTES_32},
      '{pfc_pkg::FMT_ARGB8888, pfc_pkg::FMT_ARGB8888, 32'h0, 32'hFF00_0000,
        1'b1, 32'hFF00_0000, pfc_pkg::BYTES_32},
      '{pfc_pkg::FMT_RGB888,   pfc_pkg::FMT_ARGB8888, 32'h0, 32'hAB12_3456,
        1'b1, 32'hFF12_3456, pfc_pkg::BYTES_32},
      '{pfc_pkg::FMT_XRGB8888, pfc_pkg::FMT_XRGB8888, 32'h0, 32'h00AB_CDEF,
        1'b1, 32'hFFAB_CDEF, pfc_pkg::BYTES_32},
      '{pfc_pkg::FMT_RGBA,     pfc_pkg::FMT_ARGB8888, 32'h0, 32'h4433_2211,
        1'b1, 32'h4411_2233, pfc_pkg::BYTES_32},
      '{pfc_pkg::FMT_RGB565,   pfc_pkg::FMT_ARGB8888, 32'h0, 32'hFFFF_FFFF,
        1'b1, 32'hFFFF_FFFF, pfc_pkg::BYTES_32},
      '{pfc_pkg::FMT_RGB565,   pfc_pkg::FMT_ARGB8888, 32'h0, 32'hFFFF_0000,
        1'b1, 32'hFF00_0000, pfc_pkg::BYTES_32},
      '{pfc_pkg::FMT_XRGB1555, pfc_pkg::FMT_ARGB8888, 32'h0, 32'h0000_7FFF,
        1'b1, 32'hFFFF_FFFF, pfc_pkg::BYTES_32},
      '{pfc_pkg::FMT_ARGB1555, pfc_pkg::FMT_ARGB8888, 32'h0, 32'h0000_7FFF,
        1'b1, 32'h00FF_FFFF, pfc_pkg::BYTES_32},
      '{pfc_pkg::FMT_ARGB1555, pfc_pkg::FMT_ARGB8888, 32'h0, 32'h0000_8000,
        1'b1, 32'hFF00_0000, pfc_pkg::BYTES_32},
      '{pfc_pkg::FMT_ARGB4444, pfc_pkg::FMT_ARGB8888, 32'h0, 32'h0000_F0F0,
        1'b1, 32'hFF00_FF00, pfc_pkg::BYTES_32},
      '{pfc_pkg::FMT_ARGB8888, pfc_pkg::FMT_RGB888,   32'h0, 32'h80FF_FFFF,
        1'b1, 32'h00FF_FFFF, pfc_pkg::BYTES_24},
      '{pfc_pkg::FMT_ARGB8888, pfc_pkg::FMT_RGB565,   32'h0, 32'hFFFF_FFFF,
        1'b1, 32'h0000_FFFF, pfc_pkg::BYTES_16},
      '{pfc_pkg::FMT_ARGB8888, pfc_pkg::FMT_XRGB1555, 32'h0, 32'h0000_0000,
        1'b1, 32'h0000_8000, pfc_pkg::BYTES_16},
      '{pfc_pkg::FMT_ARGB8888, pfc_pkg::FMT_ARGB1555, 32'h0, 32'h80FF_FFFF,
        1'b1, 32'h0000_FFFF, pfc_pkg::BYTES_16},
      '{pfc_pkg::FMT_ARGB8888, pfc_pkg::FMT_ARGB1555, 32'h0, 32'h7FFF_FFFF,
        1'b1, 32'h0000_7FFF, pfc_pkg::BYTES_16},
      '{pfc_pkg::FMT_ARGB8888, pfc_pkg::FMT_ARGB4444, 32'h0, 32'h1234_5678,
        1'b1, 32'h0000_1357, pfc_pkg::BYTES_16},
      '{pfc_pkg::FMT_ARGB8888, pfc_pkg::FMT_RGBA,     32'h0, 32'h1234_5678,
        1'b1, 32'h1234_5678, pfc_pkg::BYTES_32},
      '{pfc_pkg::FMT_ARGB8888, pfc_pkg::FMT_ARGB8888, 32'hFF12_3456, 32'hFF12_3456,
        1'b1, 32'h0012_3456, pfc_pkg::BYTES_32},
      '{pfc_pkg::FMT_ARGB8888, pfc_pkg::FMT_ARGB8888, 32'h0100_0000, 32'hFF00_0000,
        1'b1, 32'h0000_0000, pfc_pkg::BYTES_32},
      '{pfc_pkg::FMT_ARGB8888, pfc_pkg::FMT_ARGB8888, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
        1'b1, 32'h00FF_FFFF, pfc_pkg::BYTES_32},
      '{pfc_pkg::FMT_RGB565,   pfc_pkg::FMT_ARGB8888, 32'h00FF_FFFF, 32'h0000_FFFF,
        1'b1, 32'h00FF_FFFF, pfc_pkg::BYTES_32},
      '{pfc_pkg::FMT_RGB565,   pfc_pkg::FMT_RGB565,   32'h0, 32'h0000_1234,
        1'b0, 32'h0, 3'd0},
      '{pfc_pkg::FMT_ARGB4444, pfc_pkg::FMT_ARGB1555, 32'h0, 32'h0000_8ACE,
        1'b0, 32'h0, 3'd0}
   };

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [31:0] req_source_pixel = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_dest_pixel;
   logic [2:0]  rsp_dest_bytes;
   logic                              csr_wr_en = 1'b0;
   logic [pfc_pkg::CsrIndexWidth-1:0] csr_index = '0;
   logic [pfc_pkg::CsrDataWidth-1:0]  csr_wr_data = '0;

   // register copies as the converter sees them
   pfc_pkg::fmt_type cfg_src = pfc_pkg::FMT_ARGB8888;
   pfc_pkg::fmt_type cfg_dst = pfc_pkg::FMT_ARGB8888;
   logic [31:0]      cfg_key = '0;

   dest_word_type pending_words [$];
   int            mismatch_count = 0;
   int            cycle_count = 0;
   int            tx_idle_pct = 0;
   int            rx_idle_pct = 0;
   bit            long_hold_req = 1'b0;
   int            hold_left = 0;

   pixel_format_converter i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_source_pixel (req_source_pixel),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_dest_pixel   (rsp_dest_pixel),
      .rsp_dest_bytes   (rsp_dest_bytes),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wr_data      (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // n-bit channel to 8 bits, floor(v*255/max)
   function automatic logic [7:0] expand(input int v, input int maxv);
      return 8'((v * 255) / maxv);
   endfunction

   // 8-bit channel to n bits, floor(c*max/255)
   function automatic int shrink(input logic [7:0] c, input int maxv);
      return (int'(c) * maxv) / 255;
   endfunction

   function automatic channels_type decode_word(input pfc_pkg::fmt_type fmt,
                                                input logic [31:0] word);
      channels_type c;
      logic [15:0]  h;
      h = word[15:0];
      case (fmt)
         pfc_pkg::FMT_RGB565: begin
            c = '{expand(h[15:11], 31), expand(h[10:5], 63), expand(h[4:0], 31), 8'hFF};
         end
         pfc_pkg::FMT_XRGB1555, pfc_pkg::FMT_ARGB1555: begin
            c.r = expand(h[14:10], 31);
            c.g = expand(h[9:5], 31);
            c.b = expand(h[4:0], 31);
            c.a = (fmt == pfc_pkg::FMT_ARGB1555 && !h[15]) ? 8'h00 : 8'hFF;
         end
         pfc_pkg::FMT_ARGB4444: begin
            c.r = 8'(int'(h[11:8]) * 17);
            c.g = 8'(int'(h[7:4]) * 17);
            c.b = 8'(int'(h[3:0]) * 17);
            c.a = 8'(int'(h[15:12]) * 17);
         end
         pfc_pkg::FMT_RGBA: c = '{word[7:0], word[15:8], word[23:16], word[31:24]};
         pfc_pkg::FMT_ARGB8888: c = '{word[23:16], word[15:8], word[7:0], word[31:24]};
         default: c = '{word[23:16], word[15:8], word[7:0], 8'hFF};
      endcase
      return c;
   endfunction

   // expected output word for one source pixel under the current registers
   function automatic dest_word_type convert_pixel(input logic [31:0] word);
      channels_type  c;
      dest_word_type d;
      c = decode_word(cfg_src, word);
      if (cfg_key != 0 && cfg_key[23:0] == {c.r, c.g, c.b})
         c.a = 8'h00;
      case (cfg_dst)
         pfc_pkg::FMT_RGB888: d = '{{8'h00, c.r, c.g, c.b}, pfc_pkg::BYTES_24};
         pfc_pkg::FMT_RGB565: begin
            d.pixel = 32'((shrink(c.r, 63 - 32) << 11) | (shrink(c.g, 63) << 5)
                          | shrink(c.b, 31));
            d.nbytes = pfc_pkg::BYTES_16;
         end
         pfc_pkg::FMT_XRGB1555, pfc_pkg::FMT_ARGB1555: begin
            d.pixel = 32'((shrink(c.r, 31) << 10) | (shrink(c.g, 31) << 5) | shrink(c.b, 31));
            if (cfg_dst == pfc_pkg::FMT_XRGB1555 || c.a >= 8'd128)
               d.pixel[15] = 1'b1;
            d.nbytes = pfc_pkg::BYTES_16;
         end
         pfc_pkg::FMT_ARGB4444:
            d = '{{16'h0, c.a[7:4], c.r[7:4], c.g[7:4], c.b[7:4]}, pfc_pkg::BYTES_16};
         pfc_pkg::FMT_XRGB8888: d = '{{8'hFF, c.r, c.g, c.b}, pfc_pkg::BYTES_32};
         // argb8888, and code seven encodes the same way
         default: d = '{{c.a, c.r, c.g, c.b}, pfc_pkg::BYTES_32};
      endcase
      return d;
   endfunction

   function automatic logic [31:0] random_pixel();
      case ($urandom_range(9))
         0: return 32'h0;
         1: return 32'hFFFF_FFFF;
         default: return $urandom();
      endcase
   endfunction

   // one register write; the local copy follows at the same edge
   task automatic write_reg(input logic [pfc_pkg::CsrIndexWidth-1:0] idx,
                            input logic [31:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wr_data <= data;
      @(posedge clock);
      case (idx)
         pfc_pkg::REG_SOURCE_FORMAT: cfg_src = pfc_pkg::fmt_type'(data[2:0]);
         pfc_pkg::REG_DEST_FORMAT: cfg_dst = pfc_pkg::fmt_type'(data[2:0]);
         pfc_pkg::REG_COLOR_KEY: cfg_key = data;
         default: ;
      endcase
   endtask

   // format registers get junk in their upper bits, which must be masked off
   task automatic set_config(input pfc_pkg::fmt_type src, input pfc_pkg::fmt_type dst,
                             input logic [31:0] key);
      write_reg(pfc_pkg::REG_SOURCE_FORMAT, (32'($urandom()) & ~32'h7) | 32'(src));
      write_reg(pfc_pkg::REG_DEST_FORMAT, (32'($urandom()) & ~32'h7) | 32'(dst));
      write_reg(pfc_pkg::REG_COLOR_KEY, key);
      write_reg(REG_SPARE, $urandom());
      csr_wr_en <= 1'b0;
   endtask

   // offer one word, hold it until taken, then maybe leave a gap
   task automatic send_word(input logic [31:0] pixel, input dest_word_type want);
      req_valid <= 1'b1;
      req_source_pixel <= pixel;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      pending_words.push_back(want);
      if ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   // stop sending and let the pipe empty (two stages, plus margin)
   task automatic wait_for_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_words.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // receiver: random stall, or a long hold when asked for
   always @(posedge clock) begin
      if (long_hold_req) begin
         hold_left = HoldCycles;
         long_hold_req = 1'b0;
      end
      if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else begin
         rsp_stall <= ($urandom_range(99) < rx_idle_pct);
      end
   end

   // compare each taken output word against the oldest expected one
   always @(posedge clock) begin : check_words
      dest_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_words.size() == 0) begin
            $error("unexpected word: dest_pixel %h dest_bytes %0d", rsp_dest_pixel,
                   rsp_dest_bytes);
            mismatch_count++;
         end else begin
            want = pending_words.pop_front();
            if (rsp_dest_pixel !== want.pixel) begin
               $error("dest_pixel: expected %h, got %h", want.pixel, rsp_dest_pixel);
               mismatch_count++;
            end
            if (rsp_dest_bytes !== want.nbytes) begin
               $error("dest_bytes: expected %0d, got %0d", want.nbytes, rsp_dest_bytes);
               mismatch_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CycleLimit) begin
         $display("pixel_format_converter regression: fail");
         $finish;
      end
   end

   initial begin : stimulus
      directed_row_type row;
      dest_word_type    want;
      channels_type     kc;
      pfc_pkg::fmt_type seg_src;
      pfc_pkg::fmt_type seg_dst;
      logic [31:0]      key;
      logic [31:0]      key_pixel;
      logic [31:0]      keep_mask;
      logic [31:0]      pix;
      bit               key_hits;
      int               seg_index;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      tx_idle_pct = 11;
      rx_idle_pct = 61;

      // directed rows; first row runs on the reset settings
      for (int i = 0; i < NumDirected; i++) begin
         row = DirectedRows[i];
         if (row.src != cfg_src || row.dst != cfg_dst || row.key != cfg_key) begin
            wait_for_results();
            set_config(row.src, row.dst, row.key);
         end
         want = row.typed ? dest_word_type'{row.want_pixel, row.want_bytes}
                          : convert_pixel(row.pixel);
         send_word(row.pixel, want);
      end

      // random words over rotating settings, in three idling modes
      for (int mode = 0; mode < 3; mode++) begin
         case (mode)
            0: begin tx_idle_pct = 11; rx_idle_pct = 61; end
            1: begin tx_idle_pct = 61; rx_idle_pct = 11; end
            default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
         endcase
         for (int seg = 0; seg < 7; seg++) begin
            seg_index = mode * 7 + seg;
            seg_src = pfc_pkg::fmt_type'(3'(seg_index));
            seg_dst = pfc_pkg::fmt_type'(3'(seg_index * 5 + 1));
            key_pixel = random_pixel();
            key_hits = 1'b0;
            case ($urandom_range(5))
               0, 1: key = 32'h0;
               2: key = $urandom();
               default: begin
                  // key on a real color so some words lose their alpha
                  kc = decode_word(seg_src, key_pixel);
                  key = {8'($urandom_range(255)), kc.r, kc.g, kc.b};
                  key_hits = 1'b1;
               end
            endcase
            case (seg_src)
               pfc_pkg::FMT_RGB565, pfc_pkg::FMT_XRGB1555,
               pfc_pkg::FMT_ARGB1555, pfc_pkg::FMT_ARGB4444: keep_mask = 32'h0000_FFFF;
               default: keep_mask = 32'h00FF_FFFF;
            endcase
            wait_for_results();
            set_config(seg_src, seg_dst, key);
            // output side holds off long enough to back up the input
            if (mode == 2 && seg == 0)
               long_hold_req = 1'b1;
            for (int n = 0; n < WordsPerSetting; n++) begin
               if (seg == 3 && n == WordsPerSetting / 2)
                  wait_for_results();
               pix = random_pixel();
               if (key_hits && $urandom_range(3) == 0)
                  pix = (key_pixel & keep_mask) | (pix & ~keep_mask);
               send_word(pix, convert_pixel(pix));
            end
         end
      end

      wait_for_results();
      repeat (10) @(posedge clock);
      if (pending_words.size() != 0) begin
         $error("%0d expected words never came out", pending_words.size());
         mismatch_count++;
      end
      if (mismatch_count == 0)
         $display("pixel_format_converter regression: pass");
      else
         $display("pixel_format_converter regression: fail");
      $finish;
   end

endmodule
